// ----- sv/tcst_pkg.sv -----
// Package for the touch contact slot tracker.
// Holds the shared sizes, codes, FSM states, structs and the bit-search helper.
// Has no dependencies; every other file uses it through scoped names.
package tcst_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int ID_BITS   = 32;
   localparam int SLOT_BITS = $clog2(MAX_SLOTS);

   typedef enum logic [2:0] {
      OP_BEGIN      = 3'd0,
      OP_MOVE       = 3'd1,
      OP_END        = 3'd2,
      OP_CANCEL     = 3'd3,
      OP_CANCEL_ALL = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_ACTIVE   = 3'd1,
      ST_FULL     = 3'd2,
      ST_MOVED    = 3'd3,
      ST_UNKNOWN  = 3'd4,
      ST_RELEASED = 3'd5,
      ST_IGNORED  = 3'd6,
      ST_NONE     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_RESULT = 2'd2,
      S_DRAIN  = 2'd3
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      logic [ID_BITS-1:0]   data;
   } ram_wr_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      status_type           status;
      logic                 batch_end;
      logic                 last;
   } rsp_type;

   // index of the lowest set bit, 0 when none is set
   function automatic logic [SLOT_BITS-1:0] lowest_set(input logic [MAX_SLOTS-1:0] v);
      logic [SLOT_BITS-1:0] idx;
      idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- sv/tcst_id_ram.sv -----
// Contact ID store: one entry per slot, one write and one registered read port.
// Depends on tcst_pkg for sizes. Entries are undefined until written.
module tcst_id_ram (
   input  logic                          clock,
   input  tcst_pkg::ram_wr_type          wr,
   input  logic [tcst_pkg::SLOT_BITS-1:0] rd_addr,
   output logic [tcst_pkg::ID_BITS-1:0]   rd_data
);

   logic [tcst_pkg::ID_BITS-1:0] mem [tcst_pkg::MAX_SLOTS];
   logic [tcst_pkg::ID_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tcst_ctrl.sv -----
// Sequencer of the slot tracker: serial ID search with one shared comparator,
// used bitmap, slot allocation and the cancel-all drain.
// Depends on tcst_pkg; drives tcst_id_ram.
module tcst_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          interactive,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tcst_pkg::op_type              in_op,
   input  logic [tcst_pkg::ID_BITS-1:0]   in_id,
   input  logic                          in_batch_end,
   output tcst_pkg::ram_wr_type          ram_wr,
   output logic [tcst_pkg::SLOT_BITS-1:0] ram_rd_addr,
   input  logic [tcst_pkg::ID_BITS-1:0]   ram_rd_data,
   input  logic                          out_free,
   output logic                          out_push,
   output tcst_pkg::rsp_type             out_item
);

   tcst_pkg::state_type state_ff, state_in;
   tcst_pkg::op_type    op_ff, op_in;
   logic [tcst_pkg::ID_BITS-1:0]   id_ff, id_in;
   logic                           be_ff, be_in;
   logic [tcst_pkg::MAX_SLOTS-1:0] used_ff, used_in;
   logic [tcst_pkg::MAX_SLOTS-1:0] mask_ff, mask_in;
   logic [tcst_pkg::SLOT_BITS-1:0] scan_ff, scan_in;
   logic                           pend_ff, pend_in;
   logic [tcst_pkg::SLOT_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic [tcst_pkg::SLOT_BITS-1:0] res_slot_ff, res_slot_in;
   tcst_pkg::status_type           res_status_ff, res_status_in;

   logic                           accept;
   logic                           gated;
   logic                           hit;
   logic                           scan_end;
   logic                           resolve;
   logic                           full;
   logic [tcst_pkg::SLOT_BITS-1:0] free_idx;
   logic [tcst_pkg::SLOT_BITS-1:0] low_idx;
   logic [tcst_pkg::MAX_SLOTS-1:0] mask_rest;
   logic                           drain_last;
   logic                           alloc;

   assign accept   = in_valid && in_ready;
   assign gated    = ((in_op == tcst_pkg::OP_BEGIN) || (in_op == tcst_pkg::OP_MOVE))
                     && !interactive;
   // shared comparator: entry read last cycle against the request ID
   assign hit      = pend_ff && used_ff[pend_idx_ff] && (ram_rd_data == id_ff);
   assign scan_end = pend_ff && (pend_idx_ff == tcst_pkg::SLOT_BITS'(tcst_pkg::MAX_SLOTS - 1));
   assign resolve  = (state_ff == tcst_pkg::S_SCAN) && (hit || scan_end);
   assign full     = &used_ff;
   assign free_idx = tcst_pkg::lowest_set(~used_ff);
   assign low_idx  = tcst_pkg::lowest_set(mask_ff);
   assign mask_rest = mask_ff & ~(tcst_pkg::MAX_SLOTS'(1) << low_idx);
   assign drain_last = (mask_rest == '0);
   assign alloc    = resolve && (op_ff == tcst_pkg::OP_BEGIN) && !hit && !full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcst_pkg::S_IDLE: begin
            if (accept) begin
               case (in_op)
                  tcst_pkg::OP_BEGIN, tcst_pkg::OP_MOVE: begin
                     state_in = gated ? tcst_pkg::S_RESULT : tcst_pkg::S_SCAN;
                  end
                  tcst_pkg::OP_END, tcst_pkg::OP_CANCEL: begin
                     state_in = tcst_pkg::S_SCAN;
                  end
                  tcst_pkg::OP_CANCEL_ALL: begin
                     state_in = (used_ff == '0) ? tcst_pkg::S_RESULT : tcst_pkg::S_DRAIN;
                  end
                  default: begin
                     state_in = tcst_pkg::S_RESULT;
                  end
               endcase
            end
         end
         tcst_pkg::S_SCAN: begin
            if (resolve) begin
               state_in = tcst_pkg::S_RESULT;
            end
         end
         tcst_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = tcst_pkg::S_IDLE;
            end
         end
         tcst_pkg::S_DRAIN: begin
            if (out_free && drain_last) begin
               state_in = tcst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tcst_pkg::S_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      be_in         = be_ff;
      used_in       = used_ff;
      mask_in       = mask_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         tcst_pkg::S_IDLE: begin
            if (accept) begin
               op_in         = in_op;
               id_in         = in_id;
               be_in         = in_batch_end;
               mask_in       = used_ff;
               scan_in       = '0;
               pend_in       = 1'b0;
               res_slot_in   = '0;
               res_status_in = ((in_op == tcst_pkg::OP_CANCEL_ALL) && (used_ff == '0))
                               ? tcst_pkg::ST_NONE : tcst_pkg::ST_IGNORED;
            end
         end
         tcst_pkg::S_SCAN: begin
            if (resolve) begin
               pend_in = 1'b0;
               case (op_ff)
                  tcst_pkg::OP_BEGIN: begin
                     if (hit) begin
                        res_slot_in   = pend_idx_ff;
                        res_status_in = tcst_pkg::ST_ACTIVE;
                     end else if (full) begin
                        res_slot_in   = '0;
                        res_status_in = tcst_pkg::ST_FULL;
                     end else begin
                        res_slot_in       = free_idx;
                        res_status_in     = tcst_pkg::ST_NEW;
                        used_in[free_idx] = 1'b1;
                     end
                  end
                  tcst_pkg::OP_MOVE: begin
                     res_slot_in   = hit ? pend_idx_ff : '0;
                     res_status_in = hit ? tcst_pkg::ST_MOVED : tcst_pkg::ST_UNKNOWN;
                  end
                  tcst_pkg::OP_END, tcst_pkg::OP_CANCEL: begin
                     if (hit) begin
                        res_slot_in          = pend_idx_ff;
                        res_status_in        = tcst_pkg::ST_RELEASED;
                        used_in[pend_idx_ff] = 1'b0;
                     end else begin
                        res_slot_in   = '0;
                        res_status_in = tcst_pkg::ST_UNKNOWN;
                     end
                  end
                  default: begin
                     res_slot_in   = '0;
                     res_status_in = tcst_pkg::ST_IGNORED;
                  end
               endcase
            end else begin
               // read one entry ahead of the compare
               pend_in     = 1'b1;
               pend_idx_in = scan_ff;
               scan_in     = scan_ff + tcst_pkg::SLOT_BITS'(1);
            end
         end
         tcst_pkg::S_DRAIN: begin
            if (out_free) begin
               mask_in = mask_rest;
               if (drain_last) begin
                  used_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      in_ready     = (state_ff == tcst_pkg::S_IDLE);
      ram_rd_addr  = scan_ff;
      ram_wr.en    = alloc;
      ram_wr.addr  = free_idx;
      ram_wr.data  = id_ff;
      out_push     = 1'b0;
      out_item.slot      = res_slot_ff;
      out_item.status    = res_status_ff;
      out_item.batch_end = be_ff;
      out_item.last      = 1'b1;
      case (state_ff)
         tcst_pkg::S_RESULT: begin
            out_push = out_free;
         end
         tcst_pkg::S_DRAIN: begin
            out_push           = out_free;
            out_item.slot      = low_idx;
            out_item.status    = tcst_pkg::ST_RELEASED;
            out_item.batch_end = be_ff && drain_last;
            out_item.last      = drain_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcst_pkg::S_IDLE;
         used_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      be_ff         <= be_in;
      mask_ff       <= mask_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
   end

endmodule

// ----- sv/touch_contact_slot_tracker_core.sv -----
// Top level of the touch contact slot tracker: stream ports, control register,
// result register. Depends on tcst_pkg, tcst_ctrl and tcst_id_ram.
//
// Usage:
//  - req_* carries one contact event per request: operation (begin, move, end,
//    cancel, cancel all), contact ID, and the batch marker on req_tlast.
//  - rsp_* returns results: slot and status in rsp_tdata, the batch marker on
//    rsp_tuser, and rsp_tlast on the final result of each request.
//  - csr_* is an APB-style port with one register, interactive, at address 0.
//    It resets to 1; write it only while no request is in flight.
// Sequencing:
//  - Begin, move, end and cancel search the ID table one slot per cycle
//    through the single read port of the ID store, stopping at a hit or after
//    the last slot. Ignored requests and empty cancel all skip the search and
//    go straight to the result state.
//  - Cancel all gives one result per active slot, ascending, on consecutive
//    cycles while rsp_tready does not stall; the sequencer enters its drain
//    state after accept and pushes each result into the result register.
//  - req_tready is high only while idle; one request is worked at a time.
// Reset clears the used bitmap, sequencer state and result valid; ID entries
// stay stale but are only matched behind a set used bit. A stalled rsp_tready
// holds the result register and the sequencer waits; nothing is dropped.
module touch_contact_slot_tracker_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] operation, [34:3] touch_id, [39:35] zero
   input  logic        req_tlast,   // last_in_batch
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] slot, [6:4] status, [7] zero
   output logic        rsp_tuser,   // batch_end
   output logic        rsp_tlast,   // last result of this request
   // control registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_INTERACTIVE = 1'b0;  // word index of the register

   logic interactive_ff, interactive_in;
   logic csr_wr;

   logic                 rsp_valid_ff, rsp_valid_in;
   tcst_pkg::rsp_type    rsp_ff, rsp_in;

   logic                           out_free;
   logic                           out_push;
   tcst_pkg::rsp_type              out_item;
   tcst_pkg::ram_wr_type           ram_wr;
   logic [tcst_pkg::SLOT_BITS-1:0] ram_rd_addr;
   logic [tcst_pkg::ID_BITS-1:0]   ram_rd_data;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      interactive_in = interactive_ff;
      if (csr_wr && (csr_paddr[2] == REG_INTERACTIVE)) begin
         interactive_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_INTERACTIVE) ? {31'd0, interactive_ff} : 32'd0;

   // result register: free when empty or being taken this cycle
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = out_push || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = out_push ? out_item : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interactive_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         interactive_ff <= interactive_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.status, rsp_ff.slot};
   assign rsp_tuser  = rsp_ff.batch_end;
   assign rsp_tlast  = rsp_ff.last;

   tcst_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .interactive  (interactive_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_op        (tcst_pkg::op_type'(req_tdata[2:0])),
      .in_id        (req_tdata[34:3]),
      .in_batch_end (req_tlast),
      .ram_wr       (ram_wr),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .out_free     (out_free),
      .out_push     (out_push),
      .out_item     (out_item)
   );

   tcst_id_ram u_id_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
